@@ src/gspl_pkg.sv @@
// ----------------------------------------------------------------------------
// gspl_pkg
// shared constants for the grid step path length unit
// ----------------------------------------------------------------------------
package gspl_pkg;

   // default geometry and word widths
   localparam int DEF_MAX_COLUMNS = 64;
   localparam int DEF_VALUE_BITS  = 8;
   localparam int DEF_LENGTH_BITS = 11;

   // columns register
   localparam int               COLUMNS_BITS  = 7;
   localparam [COLUMNS_BITS-1:0] COLUMNS_RESET = 7'd64;

endpackage

@@ src/gspl_ram.sv @@
// ----------------------------------------------------------------------------
// gspl_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module gspl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/grid_step_path_length_unit.sv @@
// ----------------------------------------------------------------------------
// grid_step_path_length_unit
// longest right/down path length per cell of a row-major streamed grid
// ----------------------------------------------------------------------------
// response: registered, valid in the cycle after its request word is accepted
// throughput: one word per cycle while the response is taken (rsp_tready), set by the
//    single row buffer read issued ahead for the next column (a bypass covers same-address writes)
// reset: synchronous, clears grid state and columns to 64; the row buffer is
//    not cleared, no clearing pass is needed
// ----------------------------------------------------------------------------
module grid_step_path_length_unit
   import gspl_pkg::*;
#(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int VALUE_BITS  = DEF_VALUE_BITS,
   parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // config write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [COLUMNS_BITS-1:0]               csr_data,   // columns
   // request stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((VALUE_BITS+7)/8)*8-1:0]       req_tdata,  // cell_value
   input  logic                                  req_tlast,  // last_cell
   // response stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((2*LENGTH_BITS+7)/8)*8-1:0]    rsp_tdata,  // path_length, best_length
   output logic                                  rsp_tlast   // grid_done
);

   localparam int CW     = $clog2(MAX_COLUMNS);
   localparam int WB     = (CW + 1 > COLUMNS_BITS) ? CW + 1 : COLUMNS_BITS;
   localparam int RW     = VALUE_BITS + LENGTH_BITS;
   localparam int RSP_W  = ((2*LENGTH_BITS+7)/8)*8;
   localparam [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

   // state
   logic [COLUMNS_BITS-1:0] columns_ff, columns_in;
   logic [CW-1:0]           col_ff, col_in;
   logic                    first_row_ff, first_row_in;
   logic [VALUE_BITS-1:0]   left_value_ff, left_value_in;
   logic [LENGTH_BITS-1:0]  left_length_ff, left_length_in;
   logic [LENGTH_BITS-1:0]  best_ff, best_in;
   logic                    byp_hit_ff, byp_hit_in;
   logic [RW-1:0]           byp_data_ff, byp_data_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [LENGTH_BITS-1:0]  rsp_path_ff, rsp_path_in;
   logic [LENGTH_BITS-1:0]  rsp_best_ff, rsp_best_in;
   logic                    rsp_last_ff, rsp_last_in;

   // datapath
   logic                    accept;
   logic [VALUE_BITS-1:0]   cell_value;
   logic [RW-1:0]           ram_rd_data;
   logic [RW-1:0]           up_word;
   logic [VALUE_BITS-1:0]   up_value;
   logic [LENGTH_BITS-1:0]  up_length;
   logic                    left_ok, up_ok;
   logic [LENGTH_BITS-1:0]  best_prev, len_cur, best_cur;
   logic [WB-1:0]           width_eff, col_plus;
   logic                    wrap;
   logic [CW-1:0]           col_next;

   // values differ by at most one
   function automatic logic near_enough(input logic [VALUE_BITS-1:0] a,
                                        input logic [VALUE_BITS-1:0] b);
      logic [VALUE_BITS:0] ae;
      logic [VALUE_BITS:0] be;
      ae = {1'b0, a};
      be = {1'b0, b};
      return (ae == be) || (ae == be + 1'b1) || (be == ae + 1'b1);
   endfunction

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign cell_value = req_tdata[VALUE_BITS-1:0];

   // effective row width, clamped to one and to the buffer depth
   always_comb begin
      if (columns_ff == '0) begin
         width_eff = WB'(1);
      end else if (WB'(columns_ff) > WB'(MAX_COLUMNS)) begin
         width_eff = WB'(MAX_COLUMNS);
      end else begin
         width_eff = WB'(columns_ff);
      end
   end

   // upper neighbor with bypass of a write to the address just read
   assign up_word   = byp_hit_ff ? byp_data_ff : ram_rd_data;
   assign up_value  = up_word[RW-1:LENGTH_BITS];
   assign up_length = up_word[LENGTH_BITS-1:0];

   // pick the best qualifying neighbor and extend it
   always_comb begin
      left_ok   = (col_ff != '0) && near_enough(cell_value, left_value_ff);
      up_ok     = !first_row_ff && near_enough(cell_value, up_value);
      best_prev = '0;
      if (left_ok && left_length_ff > best_prev) begin
         best_prev = left_length_ff;
      end
      if (up_ok && up_length > best_prev) begin
         best_prev = up_length;
      end
      len_cur  = (best_prev == LEN_MAX) ? LEN_MAX : best_prev + 1'b1;
      best_cur = (len_cur > best_ff) ? len_cur : best_ff;
   end

   // column advance and row wrap
   always_comb begin
      col_plus = WB'(col_ff) + 1'b1;
      wrap     = col_plus >= width_eff;
      col_next = wrap ? '0 : col_plus[CW-1:0];
   end

   // next state
   always_comb begin
      columns_in     = csr_valid ? csr_data : columns_ff;
      col_in         = col_ff;
      first_row_in   = first_row_ff;
      left_value_in  = left_value_ff;
      left_length_in = left_length_ff;
      best_in        = best_ff;
      if (accept) begin
         if (req_tlast) begin
            col_in         = '0;
            first_row_in   = 1'b1;
            left_value_in  = '0;
            left_length_in = '0;
            best_in        = '0;
         end else begin
            col_in         = col_next;
            first_row_in   = wrap ? 1'b0 : first_row_ff;
            left_value_in  = cell_value;
            left_length_in = len_cur;
            best_in        = best_cur;
         end
      end
      byp_hit_in  = accept && (col_ff == col_in);
      byp_data_in = {cell_value, len_cur};
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_path_in  = rsp_path_ff;
      rsp_best_in  = rsp_best_ff;
      rsp_last_in  = rsp_last_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_path_in  = len_cur;
         rsp_best_in  = best_cur;
         rsp_last_in  = req_tlast;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff     <= COLUMNS_RESET;
         col_ff         <= '0;
         first_row_ff   <= 1'b1;
         left_value_ff  <= '0;
         left_length_ff <= '0;
         best_ff        <= '0;
         byp_hit_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         columns_ff     <= columns_in;
         col_ff         <= col_in;
         first_row_ff   <= first_row_in;
         left_value_ff  <= left_value_in;
         left_length_ff <= left_length_in;
         best_ff        <= best_in;
         byp_hit_ff     <= byp_hit_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byp_data_ff <= byp_data_in;
      rsp_path_ff <= rsp_path_in;
      rsp_best_ff <= rsp_best_in;
      rsp_last_ff <= rsp_last_in;
   end

   // previous row buffer: value and length per column
   gspl_ram #(
      .WIDTH (RW),
      .DEPTH (MAX_COLUMNS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data ({cell_value, len_cur}),
      .rd_addr (col_in),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_best_ff, rsp_path_ff});
   assign rsp_tlast  = rsp_last_ff;

endmodule
